@@ sv/uitf_pkg.sv @@
package uitf_pkg;

	localparam int PORTS     = 4;
	localparam int BUF_BYTES = 64;

	localparam int PORT_W = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int IDLE_W = 8;

	localparam int PIW       = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int MEM_DEPTH = PORTS * BUF_BYTES;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int QCW       = $clog2(PORTS + 1);

	localparam logic       CMD_BYTE = 1'b0;
	localparam logic       CMD_TICK = 1'b1;
	localparam logic [7:0] TIMEOUT_RESET = 8'd10;

	typedef logic [PORT_W-1:0] port_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [IDLE_W-1:0] idle_t;
	typedef logic [PIW-1:0]    pidx_t;
	typedef logic [AW-1:0]     addr_t;

	typedef struct packed {
		port_t port;
		len_t  len;
		logic  dropped;
	} job_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		byte_t data;
	} mem_wr_t;

	typedef struct packed {
		logic  en;
		pidx_t port;
	} release_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EMIT
	} back_state_t;

	function automatic addr_t buf_addr(pidx_t p, len_t pos);
		return AW'(p) * AW'(BUF_BYTES) + AW'(pos);
	endfunction

endpackage

@@ sv/uitf_ifs.sv @@
interface uitf_in_if;
	import uitf_pkg::*;
	logic  valid;
	logic  ready;
	logic  command;
	port_t port;
	byte_t rx_byte;

	modport source (output valid, command, port, rx_byte, input ready);
	modport sink (input valid, command, port, rx_byte, output ready);
endinterface

interface uitf_out_if;
	import uitf_pkg::*;
	logic  valid;
	logic  ready;
	port_t port_res;
	byte_t frame_byte;
	len_t  frame_length;
	logic  last;
	logic  dropped;

	modport source (output valid, port_res, frame_byte, frame_length, last, dropped,
		input ready);
	modport sink (input valid, port_res, frame_byte, frame_length, last, dropped,
		output ready);
endinterface

interface uitf_cfg_if;
	import uitf_pkg::*;
	logic  valid;
	logic  ready;
	idle_t data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ sv/uart_idle_timeout_framer.sv @@
// channel  | dir | word carried
// ---------+-----+------------------------------------------------
// rx_in    | in  | command, port, rx_byte: one byte or one tick
// cfg      | in  | data: idle_timeout_ticks
// frm_out  | out | port_res, frame_byte, frame_length, last, dropped
//
// An input word is taken whenever rx_in.ready is high. Each frame byte is read from
// memory, then loaded into the output register; a dropped frame leaves as a single
// zero word with no memory read. The job is popped first. A byte for a port whose
// frame is still queued or being read out is held until its last word is loaded.
// Reset clears counters, flags and the job queue; the frame memory is not cleared.
module uart_idle_timeout_framer (
	input logic         clk,
	input logic         arst_n,
	uitf_in_if.sink     rx_in,
	uitf_cfg_if.sink    cfg,
	uitf_out_if.source  frm_out
);
	import uitf_pkg::*;

	logic     q_push, q_pop, q_empty, q_full;
	job_t     push_job, pop_job;
	mem_wr_t  mem_wr;
	release_t rel;

	uitf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_in  (rx_in),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job),
		.mem_wr (mem_wr),
		.rel    (rel)
	);

	uitf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	uitf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_wr  (mem_wr),
		.q_empty (q_empty),
		.q_job   (pop_job),
		.q_pop   (q_pop),
		.rel     (rel),
		.frm_out (frm_out)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("frame job pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("frame job popped from empty queue");

	a_drop_single: assert property (@(posedge clk) disable iff (!arst_n)
		frm_out.valid && frm_out.dropped |-> frm_out.last && frm_out.frame_byte == '0)
		else $error("dropped frame word not a single zero word");

	a_release_done: assert property (@(posedge clk) disable iff (!arst_n)
		rel.en |=> frm_out.valid && frm_out.last)
		else $error("port released without final word");

endmodule

@@ sv/uitf_front.sv @@
module uitf_front (
	input  logic               clk,
	input  logic               arst_n,
	uitf_in_if.sink            rx_in,
	uitf_cfg_if.sink           cfg,
	input  logic               q_full,
	output logic               q_push,
	output uitf_pkg::job_t     q_job,
	output uitf_pkg::mem_wr_t  mem_wr,
	input  uitf_pkg::release_t rel
);
	import uitf_pkg::*;

	len_t  fill_q [PORTS];
	idle_t idle_q [PORTS];
	logic  ovf_q  [PORTS];
	logic  busy_q [PORTS];
	idle_t timeout_q;

	logic  accept, in_range, is_byte, is_tick, fire, room;
	pidx_t pi;
	idle_t idle_inc;

	assign in_range = int'(rx_in.port) < PORTS;
	assign pi       = PIW'(rx_in.port);
	assign is_byte  = in_range && (rx_in.command == CMD_BYTE);
	assign is_tick  = in_range && (rx_in.command == CMD_TICK);

	// hold bytes for a port whose frame is still queued or being read out, and all words while the queue is full
	assign rx_in.ready = !q_full && !(is_byte && busy_q[pi]);
	assign accept      = rx_in.valid && rx_in.ready;
	assign cfg.ready   = 1'b1;

	assign idle_inc = (idle_q[pi] == '1) ? idle_q[pi] : idle_q[pi] + 1'b1;
	assign room     = fill_q[pi] < LEN_W'(BUF_BYTES);
	assign fire     = accept && is_tick && (fill_q[pi] != '0) && (idle_inc >= timeout_q);

	assign q_push        = fire;
	assign q_job.port    = rx_in.port;
	assign q_job.len     = fill_q[pi];
	assign q_job.dropped = ovf_q[pi];

	assign mem_wr.en   = accept && is_byte && room;
	assign mem_wr.addr = buf_addr(pi, fill_q[pi]);
	assign mem_wr.data = rx_in.rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			for (int i = 0; i < PORTS; i++) begin
				fill_q[i] <= '0;
				idle_q[i] <= '0;
				ovf_q[i]  <= 1'b0;
				busy_q[i] <= 1'b0;
			end
		end else begin
			if (cfg.valid) begin
				timeout_q <= cfg.data;
			end
			if (rel.en) begin
				busy_q[rel.port] <= 1'b0;
			end
			if (accept && is_byte) begin
				idle_q[pi] <= '0;
				if (room) begin
					fill_q[pi] <= fill_q[pi] + 1'b1;
				end else begin
					ovf_q[pi] <= 1'b1;
				end
			end
			if (accept && is_tick) begin
				idle_q[pi] <= idle_inc;
			end
			if (fire) begin
				fill_q[pi] <= '0;
				ovf_q[pi]  <= 1'b0;
				busy_q[pi] <= 1'b1;
			end
		end
	end

endmodule

@@ sv/uitf_queue.sv @@
module uitf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uitf_pkg::job_t push_job,
	input  logic           pop,
	output uitf_pkg::job_t pop_job,
	output logic           empty,
	output logic           full
);
	import uitf_pkg::*;

	job_t             slot_q [PORTS];
	pidx_t            wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]   count_q;

	function automatic pidx_t next_ptr(pidx_t p);
		return (int'(p) == PORTS - 1) ? '0 : p + 1'b1;
	endfunction

	assign empty   = (count_q == '0);
	assign full    = (count_q == QCW'(PORTS));
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop && !empty) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/uitf_back.sv @@
module uitf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  uitf_pkg::mem_wr_t  mem_wr,
	input  logic               q_empty,
	input  uitf_pkg::job_t     q_job,
	output logic               q_pop,
	output uitf_pkg::release_t rel,
	uitf_out_if.source         frm_out
);
	import uitf_pkg::*;

	byte_t mem [MEM_DEPTH];

	back_state_t state_q, state_d;
	job_t        job_q;
	len_t        idx_q;
	byte_t       rd_data_q;
	logic        rd_en, load, last_now;
	logic        ov_q;
	port_t       port_q;
	byte_t       byte_q;
	len_t        len_q;
	logic        last_q, drop_q;

	assign last_now = job_q.dropped || (LEN_W'(idx_q + 1'b1) == job_q.len);

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[buf_addr(PIW'(job_q.port), idx_q)];
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		load    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = q_job.dropped ? BK_EMIT : BK_READ;
				end
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				// advance only once the output register is free
				if (!ov_q || frm_out.ready) begin
					load    = 1'b1;
					state_d = last_now ? BK_IDLE : BK_READ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign rel.en   = load && last_now;
	assign rel.port = PIW'(job_q.port);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (frm_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			idx_q <= '0;
		end else if (load && !last_now) begin
			idx_q <= idx_q + 1'b1;
		end
		if (load) begin
			port_q <= job_q.port;
			byte_q <= job_q.dropped ? '0 : rd_data_q;
			len_q  <= job_q.len;
			last_q <= last_now;
			drop_q <= job_q.dropped;
		end
	end

	assign frm_out.valid        = ov_q;
	assign frm_out.port_res     = port_q;
	assign frm_out.frame_byte   = byte_q;
	assign frm_out.frame_length = len_q;
	assign frm_out.last         = last_q;
	assign frm_out.dropped      = drop_q;

endmodule
